### rtl/assert_macros.svh
// Shared assertion macros for the block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a |=> c, skipped while in reset
`define ACS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");

// a |-> c, skipped while in reset
`define ACS_ASSERT_SAME(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("same-cycle check failed");

// a |=> c, also checked during reset
`define ACS_ASSERT_NEXT_NR(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("reset check failed");

`endif

### rtl/acs_pkg.sv
package acs_pkg;

  localparam int DEF_MAX_NODES   = 64;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam logic [1:0] REQ_PHER = 2'd0;
  localparam logic [1:0] REQ_NODE = 2'd1;
  localparam logic [1:0] REQ_MOVE = 2'd2;

  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_BETA  = 1'b1;

  typedef struct packed {
    logic load;       // input request accepted this cycle
    logic issue;      // push node index into the weight pipe
    logic scan;       // second pass: look for the selected node
    logic mul_start;  // latch total, clear accumulator
    logic mul_step;   // one bit of value * total
  } acs_cmd_t;

  typedef struct packed {
    logic       acc_zero;
    logic       found;
    logic [5:0] next_node;
  } acs_status_t;

  // 256*log2(x), Mitchell approximation, x > 0
  function automatic logic [11:0] acs_log2(input logic [15:0] x);
    logic [3:0]  m;
    logic [15:0] n;
    m = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) m = 4'(i);
    end
    n = x << (4'd15 - m);
    return {m, n[14:7]};
  endfunction

endpackage

### rtl/acs_in_if.sv
interface acs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  from_node;
  logic [5:0]  to_node;
  logic [15:0] value;
  logic        in_search;

  modport source(output valid, req_type, from_node, to_node, value, in_search, input ready);
  modport sink(input valid, req_type, from_node, to_node, value, in_search, output ready);
endinterface

### rtl/acs_out_if.sv
interface acs_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] next_node;
  logic       found;

  modport source(output valid, next_node, found, input ready);
  modport sink(input valid, next_node, found, output ready);
endinterface

### rtl/acs_cfg_if.sv
interface acs_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/ant_colony_next_node_select_unit.sv
// Ant colony next-node selection (roulette wheel over a pheromone matrix).
// in_chan: requests. req_type 0 writes pheromone[from][to] (Q8.8),
//   1 writes node to's attractiveness (Q0.16) and its visited bit
//   (in_search=1 makes it selectable), 2 moves from node from_node with
//   random draw value (Q0.16), 3 does nothing.
// out_chan: one result per request: next_node and found (0 unless a move
//   picked a node).
// cfg_chan: index 0 alpha, 1 beta, Q4.4 exponents; always ready; write only
//   while no request is in flight.
// Writes and no-ops give their result in the cycle after acceptance.
// A move makes one pass over all nodes through a 3-stage weight pipe to
// sum, a bit-serial shift-add for value*total, and a second pass to find
// the first node whose running sum reaches it. With a zero total it skips
// the shift-add and the second pass.
// One request is worked on at a time.
// Reset clears the visited bitmap to all ones (nothing selectable) and sets
// alpha = beta = 1.0; pheromone and node memories are not cleared.
// A stalled result holds in the output register; a new request is taken
// once that register is free or being emptied.
module ant_colony_next_node_select_unit #(
  parameter int MAX_NODES   = acs_pkg::DEF_MAX_NODES,
  parameter int WEIGHT_BITS = acs_pkg::DEF_WEIGHT_BITS
) (
  input logic       clk,
  input logic       rst_n,
  acs_in_if.sink    in_chan,
  acs_out_if.source out_chan,
  acs_cfg_if.sink   cfg_chan
);
  import acs_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);

  acs_cmd_t         cmd;
  acs_status_t      st;
  logic [IDX_W-1:0] issue_idx;

  acs_ctrl #(
    .MAX_NODES(MAX_NODES),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .st(st),
    .cmd(cmd),
    .issue_idx(issue_idx)
  );

  acs_dp #(
    .MAX_NODES(MAX_NODES),
    .WEIGHT_BITS(WEIGHT_BITS),
    .IDX_W(IDX_W)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_chan(cfg_chan),
    .req_type(in_chan.req_type),
    .from_node(in_chan.from_node),
    .to_node(in_chan.to_node),
    .value(in_chan.value),
    .in_search(in_chan.in_search),
    .cmd(cmd),
    .issue_idx(issue_idx),
    .st(st)
  );

endmodule

### rtl/acs_dp.sv
module acs_dp #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16,
  parameter int IDX_W       = $clog2(MAX_NODES)
) (
  input  logic               clk,
  input  logic               rst_n,
  acs_cfg_if.sink            cfg_chan,
  input  logic [1:0]         req_type,
  input  logic [5:0]         from_node,
  input  logic [5:0]         to_node,
  input  logic [15:0]        value,
  input  logic               in_search,
  input  acs_pkg::acs_cmd_t  cmd,
  input  logic [IDX_W-1:0]   issue_idx,
  output acs_pkg::acs_status_t st
);
  import acs_pkg::*;

  localparam int PADDR_W = 2 * IDX_W;
  localparam int PDEPTH  = MAX_NODES * MAX_NODES;
  localparam int ACC_W   = WEIGHT_BITS + IDX_W;
  localparam int TGT_W   = ACC_W + 16;
  localparam int SHW     = WEIGHT_BITS + 13;
  localparam logic signed [24:0] S_BIAS = 25'(WEIGHT_BITS / 2 * 4096);
  localparam logic [12:0] IP_LIM = 13'(WEIGHT_BITS);
  localparam logic [WEIGHT_BITS-1:0] MAXW = '1;
  localparam logic [PADDR_W-1:0] NROW = PADDR_W'(MAX_NODES);

  logic [7:0] alpha_r, beta_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 8'd16;
      beta_r  <= 8'd16;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_ALPHA: alpha_r <= cfg_chan.data;
        CFG_BETA:  beta_r  <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // request decode
  logic             from_ok, to_ok;
  logic [IDX_W-1:0] from_idx, to_idx, from_r;
  logic [15:0]      val_r;

  assign from_ok  = 32'(from_node) < MAX_NODES;
  assign to_ok    = 32'(to_node) < MAX_NODES;
  assign from_idx = IDX_W'(from_node);
  assign to_idx   = IDX_W'(to_node);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      from_r <= from_idx;
      val_r  <= value;
    end
  end

  // storage
  logic [15:0]          pher_mem [PDEPTH];
  logic [15:0]          node_mem [MAX_NODES];
  logic [MAX_NODES-1:0] visited_r;
  logic [PADDR_W-1:0]   waddr, raddr;
  logic [15:0]          tau_r, eta_r;

  assign waddr = PADDR_W'(from_idx) * NROW + PADDR_W'(to_idx);
  assign raddr = PADDR_W'(from_r) * NROW + PADDR_W'(issue_idx);

  always_ff @(posedge clk) begin
    if (cmd.load && req_type == REQ_PHER && from_ok && to_ok) pher_mem[waddr] <= value;
    tau_r <= pher_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && req_type == REQ_NODE && to_ok) node_mem[to_idx] <= value;
    eta_r <= node_mem[issue_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '1;
    end else if (cmd.load) begin
      if (req_type == REQ_NODE && to_ok) visited_r[to_idx] <= ~in_search;
      if (req_type == REQ_MOVE && from_ok) visited_r[from_idx] <= 1'b1;
    end
  end

  // weight pipe: read -> log/multiply -> exp2 -> accumulate
  logic             v1_r, v2_r, v3_r, vis_r, zero2_r;
  logic [IDX_W-1:0] j1_r, j2_r, j3_r;
  logic signed [22:0] pa_r, pb_r, pa_nxt, pb_nxt;
  logic [WEIGHT_BITS-1:0] w3_r, w_nxt;
  logic [11:0]        lt, le;
  logic signed [13:0] lp, la;
  logic               zero_nxt;

  always_comb begin
    lt = acs_log2(tau_r);
    le = acs_log2(eta_r);
    lp = $signed({2'b00, lt}) - 14'sd2048;
    la = $signed({2'b00, le}) - 14'sd4096;
    pa_nxt = $signed({1'b0, alpha_r}) * lp;
    pb_nxt = $signed({1'b0, beta_r}) * la;
    zero_nxt = vis_r || (alpha_r != 8'd0 && tau_r == 16'd0) ||
               (beta_r != 8'd0 && eta_r == 16'd0);
  end

  logic signed [24:0] s;
  logic [12:0]        ip;
  logic [12:0]        mant;
  logic [SHW-1:0]     wide;

  always_comb begin
    s    = pa_r + pb_r + S_BIAS;
    ip   = s[24:12];
    mant = {1'b1, s[11:0]};
    wide = (SHW'(mant) << ip[5:0]) >> 12;
    if (zero2_r || s[24]) begin
      w_nxt = '0;
    end else if (ip >= IP_LIM) begin
      w_nxt = MAXW;
    end else if (wide > SHW'(MAXW)) begin
      w_nxt = MAXW;
    end else begin
      w_nxt = WEIGHT_BITS'(wide);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    vis_r   <= visited_r[issue_idx];
    j1_r    <= issue_idx;
    j2_r    <= j1_r;
    j3_r    <= j2_r;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    zero2_r <= zero_nxt;
    w3_r    <= w_nxt;
  end

  // running sum, product value*total, and first-hit detect
  logic [ACC_W-1:0] acc_r, mcand_r, run;
  logic [TGT_W-1:0] tgt_r;
  logic [15:0]      mpl_r;
  logic             found_r, hit;
  logic [5:0]       node_r;

  assign run = acc_r + ACC_W'(w3_r);
  assign hit = cmd.scan && v3_r && !found_r && (w3_r != '0) && ({run, 16'd0} >= tgt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.load) begin
      acc_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.mul_start) begin
      acc_r <= '0;
    end else begin
      if (v3_r) acc_r <= run;
      if (hit) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) node_r <= 6'(j3_r);
    if (cmd.mul_start) begin
      mcand_r <= acc_r;
      mpl_r   <= val_r;
      tgt_r   <= '0;
    end else if (cmd.mul_step) begin
      tgt_r <= (tgt_r << 1) + (mpl_r[15] ? TGT_W'(mcand_r) : TGT_W'(0));
      mpl_r <= mpl_r << 1;
    end
  end

  assign st.acc_zero  = (acc_r == '0);
  assign st.found     = found_r;
  assign st.next_node = found_r ? node_r : 6'd0;

endmodule

### rtl/acs_ctrl.sv
module acs_ctrl #(
  parameter int MAX_NODES = 64,
  parameter int IDX_W     = $clog2(MAX_NODES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  acs_in_if.sink               in_chan,
  acs_out_if.source            out_chan,
  input  acs_pkg::acs_status_t st,
  output acs_pkg::acs_cmd_t    cmd,
  output logic [IDX_W-1:0]     issue_idx
);
  import acs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SUM    = 3'd1;
  localparam logic [2:0] S_SDRAIN = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_XDRAIN = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_NODES - 1);

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt, of_r, of_nxt;
  logic [5:0]       on_r, on_nxt;
  logic             out_free, accept, is_move;

  assign out_free      = !ov_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && out_free;
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_move       = (in_chan.req_type == REQ_MOVE) && (32'(in_chan.from_node) < MAX_NODES);
  assign issue_idx     = j_r;

  assign out_chan.valid     = ov_r;
  assign out_chan.next_node = on_r;
  assign out_chan.found     = of_r;

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_chan.ready;
    of_nxt    = of_r;
    on_nxt    = on_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          j_nxt    = '0;
          if (is_move) begin
            state_nxt = S_SUM;
          end else begin
            ov_nxt = 1'b1;
            of_nxt = 1'b0;
            on_nxt = 6'd0;
          end
        end
      end
      S_SUM, S_SCAN: begin
        cmd.issue = 1'b1;
        cmd.scan  = (state_r == S_SCAN);
        j_nxt     = j_r + 1'b1;
        cnt_nxt   = 4'd0;
        if (j_r == LAST) state_nxt = (state_r == S_SUM) ? S_SDRAIN : S_XDRAIN;
      end
      S_SDRAIN: begin
        cnt_nxt = cnt_r + 4'd1;
        // pipe holds three stages; the check waits until the sum is final
        if (cnt_r == 4'd3) begin
          cnt_nxt = 4'd0;
          if (st.acc_zero) begin
            state_nxt = S_OUT;
          end else begin
            cmd.mul_start = 1'b1;
            state_nxt     = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          j_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end
      S_XDRAIN: begin
        cmd.scan = 1'b1;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd3) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          of_nxt    = st.found;
          on_nxt    = st.next_node;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      j_r     <= '0;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    of_r <= of_nxt;
    on_r <= on_nxt;
  end

endmodule

### rtl/acs_checker.sv
`include "assert_macros.svh"

module acs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_next_node,
  input logic       out_found
);
  import acs_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  `ACS_ASSERT_NEXT_NR(a_reset_empty, clk, !rst_n, !out_valid)
  `ACS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_next_node) && $stable(out_found))
  `ACS_ASSERT_SAME(a_none_zero, clk, rst_n, out_valid && !out_found, out_next_node == 6'd0)
  `ACS_ASSERT_NEXT(a_write_result, clk, rst_n, in_acc && in_req_type != REQ_MOVE, out_valid && !out_found)

endmodule

bind ant_colony_next_node_select_unit acs_checker u_acs_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_chan.valid),
  .in_ready(in_chan.ready),
  .in_req_type(in_chan.req_type),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_next_node(out_chan.next_node),
  .out_found(out_chan.found)
);
